// ===== rtl/core/wsled_pkg.sv =====
package wsled_pkg;

    // Field widths
    localparam int COLOR_W = 8;
    localparam int FRAME_W = 3 * COLOR_W;
    localparam int TICK_W  = 15;
    localparam int MODE_W  = 3;
    localparam int PHASE_W = 8;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = $clog2(FRAME_W);

    // Blink period default
    localparam int BLINK_PHASES_DEF = 10;

    // Request queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request types
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_RAW  = 1'b1;

    // LED mode codes
    localparam logic [MODE_W-1:0] MODE_OFF          = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GREEN        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_YELLOW       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RED          = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RED_BLINK    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ORANGE_BLINK = 3'd5;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_LED_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ZERO_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZERO_LOW  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_ONE_LOW   = 3'd4;

    // Register reset values
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 15'd4;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 15'd8;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 15'd7;
    localparam logic [TICK_W-1:0] ONE_LOW_RST   = 15'd6;

    // Status colour levels
    localparam logic [COLOR_W-1:0] LVL_FULL   = 8'd32;
    localparam logic [COLOR_W-1:0] LVL_YELLOW = 8'd24;
    localparam logic [COLOR_W-1:0] LVL_ORANGE = 8'd10;

    // Front to queue
    typedef struct packed {
        logic               push;
        logic [FRAME_W-1:0] frame;
    } queue_wr_t;

    // Queue to back
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } queue_rd_t;

    // Symbol timing registers
    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
    } tick_cfg_t;

endpackage

// ===== rtl/core/wsled_front.sv =====
module wsled_front import wsled_pkg::*; #(
    parameter int BLINK_PHASES = BLINK_PHASES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [COLOR_W-1:0] s_red,
    input  logic [COLOR_W-1:0] s_green,
    input  logic [COLOR_W-1:0] s_blue,
    input  logic [MODE_W-1:0]  led_mode,
    input  logic               queue_full,
    output queue_wr_t          wr
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] phase_wrap;
    logic               blink_on;
    logic               accept;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    // Blink phase advances on every accepted tick
    assign phase_inc  = phase_reg + PHASE_W'(1);
    assign phase_wrap = (phase_inc >= PHASE_W'(BLINK_PHASES)) ? '0 : phase_inc;
    assign blink_on   = phase_wrap < PHASE_W'(BLINK_PHASES / 2);

    always_comb begin
        phase_next = phase_reg;
        if (accept && (s_req_type == REQ_TICK)) begin
            phase_next = phase_wrap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Colour selection
    always_comb begin
        r = '0;
        g = '0;
        b = '0;
        if (s_req_type == REQ_RAW) begin
            r = s_red;
            g = s_green;
            b = s_blue;
        end else begin
            unique case (led_mode)
                MODE_GREEN: begin
                    g = LVL_FULL;
                end
                MODE_YELLOW: begin
                    r = LVL_FULL;
                    g = LVL_YELLOW;
                end
                MODE_RED: begin
                    r = LVL_FULL;
                end
                MODE_RED_BLINK: begin
                    r = blink_on ? LVL_FULL : '0;
                end
                MODE_ORANGE_BLINK: begin
                    r = blink_on ? LVL_FULL : '0;
                    g = blink_on ? LVL_ORANGE : '0;
                end
                default: begin
                    r = '0;
                end
            endcase
        end
    end

    // Wire order is green, red, blue
    assign wr.push  = accept;
    assign wr.frame = {g, r, b};

endmodule

// ===== rtl/core/wsled_queue.sv =====
module wsled_queue import wsled_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  queue_wr_t wr,
    input  logic      pop,
    output logic      full,
    output queue_rd_t rd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

    logic [FRAME_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_Q-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full     = count_reg == CNT_Q'(QUEUE_DEPTH);
    assign rd.valid = count_reg != '0;
    assign rd.frame = mem[rptr_reg];
    assign do_pop   = pop && rd.valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr.push) begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (wr.push && !do_pop) begin
            count_next = count_reg + CNT_Q'(1);
        end else if (!wr.push && do_pop) begin
            count_next = count_reg - CNT_Q'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Frame storage
    always_ff @(posedge aclk) begin
        if (wr.push) begin
            mem[wptr_reg] <= wr.frame;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.push |-> !full)
        else $error("request queue written while full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_Q'(QUEUE_DEPTH))
        else $error("request queue count out of range");

endmodule

// ===== rtl/core/wsled_back.sv =====
module wsled_back import wsled_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  queue_rd_t         rd,
    output logic              pop,
    input  tick_cfg_t         ticks,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [TICK_W-1:0] m_high_ticks,
    output logic [TICK_W-1:0] m_low_ticks,
    output logic              m_data_bit,
    output logic              m_last_symbol
);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FRAME_W-1:0] shift_reg, shift_next;
    logic               m_valid_reg, m_valid_next;
    logic [TICK_W-1:0]  m_high_reg, m_low_reg;
    logic               m_data_reg, m_last_reg;
    logic               out_free;
    logic               emit;
    logic [FRAME_W-1:0] cur_bits;
    logic [CNT_W-1:0]   cur_cnt;
    logic               cur_last;

    // Output register frees when empty or being taken
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = out_free && (busy_reg || rd.valid);
    assign pop      = emit && !busy_reg;
    assign cur_bits = busy_reg ? shift_reg : rd.frame;
    assign cur_cnt  = busy_reg ? cnt_reg : '0;
    assign cur_last = cur_cnt == CNT_W'(FRAME_W - 1);

    // Serializer control
    always_comb begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        m_valid_next = m_valid_reg;
        if (emit) begin
            busy_next    = !cur_last;
            cnt_next     = cur_cnt + CNT_W'(1);
            shift_next   = {cur_bits[FRAME_W-2:0], 1'b0};
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Symbol payload, MSB first
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (emit) begin
            m_data_reg <= cur_bits[FRAME_W-1];
            m_last_reg <= cur_last;
            m_high_reg <= cur_bits[FRAME_W-1] ? ticks.one_high : ticks.zero_high;
            m_low_reg  <= cur_bits[FRAME_W-1] ? ticks.one_low : ticks.zero_low;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_high_ticks  = m_high_reg;
    assign m_low_ticks   = m_low_reg;
    assign m_data_bit    = m_data_reg;
    assign m_last_symbol = m_last_reg;

    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0) && (cnt_reg <= CNT_W'(FRAME_W - 1)))
        else $error("symbol counter out of range while busy");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid_reg && busy_reg && (cnt_reg == CNT_W'(1)))
        else $error("frame start did not load the serializer");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && cur_last) |=> !busy_reg && m_last_reg)
        else $error("last symbol did not close the frame");

endmodule

// ===== rtl/core/ws2812_status_led_encoder.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------
// s_       | s_valid / s_ready  | s_req_type, s_red, s_green, s_blue
// m_       | m_valid / m_ready  | m_high_ticks, m_low_ticks, m_data_bit,
//          |                    | m_last_symbol
// cfg_     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each request yields 24 symbols, one per cycle from the serializer in the
// back part whenever m_ready is high.
// A request is classified as it is accepted and its frame enters the queue at
// the accepting edge; the back part then pops it into its output register.
// A two-entry frame queue lets the front take requests while the back is busy.
// Synchronous active-low reset resets the blink phase, queue and registers.
// cfg_ready is always high; symbols hold under m_ready low.
module ws2812_status_led_encoder import wsled_pkg::*; #(
    parameter int BLINK_PHASES = BLINK_PHASES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [COLOR_W-1:0] s_red,
    input  logic [COLOR_W-1:0] s_green,
    input  logic [COLOR_W-1:0] s_blue,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TICK_W-1:0]  m_high_ticks,
    output logic [TICK_W-1:0]  m_low_ticks,
    output logic               m_data_bit,
    output logic               m_last_symbol,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [TICK_W-1:0]  cfg_data
);

    logic [MODE_W-1:0] mode_reg;
    tick_cfg_t         ticks_reg;
    logic              cfg_wr;
    queue_wr_t         q_wr;
    queue_rd_t         q_rd;
    logic              q_full;
    logic              q_pop;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg            <= MODE_OFF;
            ticks_reg.zero_high <= ZERO_HIGH_RST;
            ticks_reg.zero_low  <= ZERO_LOW_RST;
            ticks_reg.one_high  <= ONE_HIGH_RST;
            ticks_reg.one_low   <= ONE_LOW_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_LED_MODE:  mode_reg            <= cfg_data[MODE_W-1:0];
                REG_ZERO_HIGH: ticks_reg.zero_high <= cfg_data;
                REG_ZERO_LOW:  ticks_reg.zero_low  <= cfg_data;
                REG_ONE_HIGH:  ticks_reg.one_high  <= cfg_data;
                REG_ONE_LOW:   ticks_reg.one_low   <= cfg_data;
                default: begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    wsled_front #(
        .BLINK_PHASES (BLINK_PHASES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_red      (s_red),
        .s_green    (s_green),
        .s_blue     (s_blue),
        .led_mode   (mode_reg),
        .queue_full (q_full),
        .wr         (q_wr)
    );

    wsled_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .pop     (q_pop),
        .full    (q_full),
        .rd      (q_rd)
    );

    wsled_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd            (q_rd),
        .pop           (q_pop),
        .ticks         (ticks_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_high_ticks  (m_high_ticks),
        .m_low_ticks   (m_low_ticks),
        .m_data_bit    (m_data_bit),
        .m_last_symbol (m_last_symbol)
    );

endmodule
